// File: hw/rtl/fcsu_pkg.sv
// ----------------------------------------------------------------------------
// fcsu_pkg
// Shared types, codes and tables of the four-channel sound unit.
// ----------------------------------------------------------------------------
package fcsu_pkg;

  localparam int WaveBytesDefault = 16;
  localparam int RegCount = 23;

  typedef enum logic [2:0] {
    KIND_REG_WRITE  = 3'd0,
    KIND_REG_READ   = 3'd1,
    KIND_WAVE_WRITE = 3'd2,
    KIND_WAVE_READ  = 3'd3,
    KIND_SAMPLE     = 3'd4,
    KIND_FRAME      = 3'd5
  } kind_t;

  localparam logic [4:0] REG_NR10 = 5'h00, REG_NR11 = 5'h01, REG_NR12 = 5'h02,
                         REG_NR13 = 5'h03, REG_NR14 = 5'h04, REG_NR21 = 5'h06,
                         REG_NR22 = 5'h07, REG_NR23 = 5'h08, REG_NR24 = 5'h09,
                         REG_NR30 = 5'h0A, REG_NR31 = 5'h0B, REG_NR32 = 5'h0C,
                         REG_NR33 = 5'h0D, REG_NR34 = 5'h0E, REG_NR41 = 5'h10,
                         REG_NR42 = 5'h11, REG_NR43 = 5'h12, REG_NR44 = 5'h13,
                         REG_NR50 = 5'h14, REG_NR51 = 5'h15, REG_NR52 = 5'h16;

  function automatic logic duty_bit(input logic [1:0] duty, input logic [2:0] step);
    logic [7:0] pat;
    begin
      case (duty)
        2'd0: pat = 8'h80;
        2'd1: pat = 8'h81;
        2'd2: pat = 8'hE1;
        default: pat = 8'h7E;
      endcase
      duty_bit = pat[step];
    end
  endfunction

  function automatic logic [15:0] noise_period(input logic [7:0] nr43);
    logic [6:0] dv;
    logic [22:0] p;
    begin
      case (nr43[2:0])
        3'd0: dv = 7'd8;
        3'd1: dv = 7'd16;
        3'd2: dv = 7'd32;
        3'd3: dv = 7'd48;
        3'd4: dv = 7'd64;
        3'd5: dv = 7'd80;
        3'd6: dv = 7'd96;
        default: dv = 7'd112;
      endcase
      p = {16'd0, dv} << nr43[7:4];
      noise_period = p[15:0];
    end
  endfunction

  // (2048 - f) * k, wrapped to 16 bits; f is up to 16 bits wide
  function automatic logic [15:0] reload(input logic [15:0] f, input logic [1:0] sh);
    logic [15:0] t;
    begin
      t = 16'd2048 - f;
      reload = t << sh;
    end
  endfunction

  function automatic logic [3:0] env_vol(input logic [3:0] vol, input logic [7:0] env);
    begin
      if (env[3] && vol != 4'd15) env_vol = vol + 4'd1;
      else if (!env[3] && vol != 4'd0) env_vol = vol - 4'd1;
      else env_vol = vol;
    end
  endfunction

endpackage

// File: hw/rtl/four_channel_sound_unit.sv
// ----------------------------------------------------------------------------
// four_channel_sound_unit
// Two square channels, a wave-table channel and a noise channel with mixer.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall) carries a beat of kind,
// reg_address, wave_address and write_data. Every accepted beat gives
// exactly one result beat on the output channel (out_valid/out_stall):
// read_data for register and wave reads, sample_valid with left/right mix
// for a sample tick, zeros otherwise.
// The result of an accepted beat is loaded into the output register.
// Throughput: one beat every cycle while in_stall is low. All state updates for a beat happen in
// the same cycle it is accepted; the result register is the only stage.
// A new beat is accepted while the output register is empty or is being
// taken in the same cycle; if the receiver stalls with a full output
// register, in_stall rises and the held result stays put.
// Reset (rst, synchronous) clears the register file, wave table, all
// channel state and the output register; the noise LFSR resets to all ones.
// ----------------------------------------------------------------------------
module four_channel_sound_unit #(
  parameter int WAVE_BYTES = fcsu_pkg::WaveBytesDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [4:0] reg_address,
  input  logic [$clog2(WAVE_BYTES)-1:0] wave_address,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       sample_valid,
  output logic [7:0] left_sample,
  output logic [7:0] right_sample
);
  import fcsu_pkg::*;

  localparam int WA = $clog2(WAVE_BYTES);

  // architectural state
  logic [7:0]  regs [RegCount];
  logic [7:0]  wave [WAVE_BYTES];
  logic [1:0]  sq_en;
  logic [2:0]  sq_step [2];
  logic [1:0]  sq_lvl;
  logic [3:0]  sq_vol [2];
  logic [15:0] sq_per [2];
  logic [6:0]  sq_len [2];
  logic [2:0]  sq_env [2];
  logic [11:0] sweep_shadow;
  logic        sweep_active;
  logic        wv_en;
  logic [4:0]  wv_pos;
  logic [3:0]  wv_lvl;
  logic [15:0] wv_per;
  logic [8:0]  wv_len;
  logic        nz_en, nz_lvl;
  logic [3:0]  nz_vol;
  logic [15:0] nz_per;
  logic [6:0]  nz_len;
  logic [2:0]  nz_env;
  logic [14:0] lfsr;
  logic [2:0]  seq;

  // next values
  logic [7:0]  regs_next [RegCount];
  logic [7:0]  wave_next [WAVE_BYTES];
  logic [1:0]  sq_en_next;
  logic [2:0]  sq_step_next [2];
  logic [1:0]  sq_lvl_next;
  logic [3:0]  sq_vol_next [2];
  logic [15:0] sq_per_next [2];
  logic [6:0]  sq_len_next [2];
  logic [2:0]  sq_env_next [2];
  logic [11:0] sweep_shadow_next;
  logic        sweep_active_next;
  logic        wv_en_next;
  logic [4:0]  wv_pos_next;
  logic [3:0]  wv_lvl_next;
  logic [15:0] wv_per_next;
  logic [8:0]  wv_len_next;
  logic        nz_en_next, nz_lvl_next;
  logic [3:0]  nz_vol_next;
  logic [15:0] nz_per_next;
  logic [6:0]  nz_len_next;
  logic [2:0]  nz_env_next;
  logic [14:0] lfsr_next;
  logic [2:0]  seq_next;

  logic        accept;
  logic [7:0]  rd_next;
  logic [3:0]  lv0, lv1, lv2, lv3;
  logic [7:0]  mix_l, mix_r;

  // combinational scratch
  logic [15:0] sf, sd;
  logic [15:0] f1;
  logic [7:0]  rb, wbyte;
  logic [3:0]  ws;
  logic        fb;
  logic [14:0] sr;
  logic [7:0]  b;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    regs_next = regs;
    wave_next = wave;
    sq_en_next = sq_en;
    sq_step_next = sq_step;
    sq_lvl_next = sq_lvl;
    sq_vol_next = sq_vol;
    sq_per_next = sq_per;
    sq_len_next = sq_len;
    sq_env_next = sq_env;
    sweep_shadow_next = sweep_shadow;
    sweep_active_next = sweep_active;
    wv_en_next = wv_en;
    wv_pos_next = wv_pos;
    wv_lvl_next = wv_lvl;
    wv_per_next = wv_per;
    wv_len_next = wv_len;
    nz_en_next = nz_en;
    nz_lvl_next = nz_lvl;
    nz_vol_next = nz_vol;
    nz_per_next = nz_per;
    nz_len_next = nz_len;
    nz_env_next = nz_env;
    lfsr_next = lfsr;
    seq_next = seq;
    rd_next = 8'd0;
    sf = 16'd0;
    sd = 16'd0;
    f1 = 16'd0;
    rb = 8'hFF;
    wbyte = 8'd0;
    ws = 4'd0;
    fb = 1'b0;
    sr = lfsr;
    b = write_data;

    case (kind)
      KIND_REG_WRITE: begin
        if (reg_address < 5'(RegCount)) begin
          if (reg_address == REG_NR52) begin
            // power off clears the whole file
            if (regs[REG_NR52][7] && !b[7]) begin
              for (int i = 0; i < RegCount; i++) regs_next[i] = 8'd0;
            end
            regs_next[REG_NR52] = {b[7], regs_next[REG_NR52][6:0]};
          end
          if (regs_next[REG_NR52][7]) begin
            regs_next[reg_address] = b;
            case (reg_address)
              REG_NR11: sq_len_next[0] = 7'd64 - {1'b0, b[5:0]};
              REG_NR21: sq_len_next[1] = 7'd64 - {1'b0, b[5:0]};
              REG_NR12: if (b[7:3] == 5'd0) sq_en_next[0] = 1'b0;
              REG_NR22: if (b[7:3] == 5'd0) sq_en_next[1] = 1'b0;
              REG_NR14: if (b[7]) begin
                f1 = {5'd0, b[2:0], regs[REG_NR13]};
                sq_en_next[0] = regs[REG_NR12][7:3] != 5'd0;
                if (sq_len[0] == 7'd0) sq_len_next[0] = 7'd64;
                sq_per_next[0] = reload(f1, 2'd2);
                sq_env_next[0] = regs[REG_NR12][2:0];
                sq_vol_next[0] = regs[REG_NR12][7:4];
                sf = f1;
                sweep_active_next = regs[REG_NR10][6:0] != 7'd0 &&
                                    (regs[REG_NR10][6:4] != 3'd0 ||
                                     regs[REG_NR10][2:0] != 3'd0);
                if (regs[REG_NR10][6:4] != 3'd0) begin
                  sd = f1 >> regs[REG_NR10][2:0];
                  sf = regs[REG_NR10][3] ? f1 - sd : f1 + sd;
                  regs_next[REG_NR13] = sf[7:0];
                  regs_next[REG_NR14] = {b[7:3], sf[10:8]};
                  sq_per_next[0] = reload(sf, 2'd2);
                  if (sf >= 16'd2048) begin
                    sq_en_next[0] = 1'b0;
                    sweep_active_next = 1'b0;
                  end
                end
                sweep_shadow_next = sf[11:0];
              end
              REG_NR24: if (b[7]) begin
                sq_en_next[1] = regs[REG_NR22][7:3] != 5'd0;
                if (sq_len[1] == 7'd0) sq_len_next[1] = 7'd64;
                sq_per_next[1] = reload({5'd0, b[2:0], regs[REG_NR23]}, 2'd2);
                sq_env_next[1] = regs[REG_NR22][2:0];
                sq_vol_next[1] = regs[REG_NR22][7:4];
              end
              REG_NR30: if (!b[7]) wv_en_next = 1'b0;
              REG_NR31: wv_len_next = 9'd256 - {1'b0, b};
              REG_NR34: if (b[7]) begin
                wv_en_next = regs[REG_NR30][7];
                if (wv_len == 9'd0) wv_len_next = 9'd256;
                wv_per_next = reload({5'd0, b[2:0], regs[REG_NR33]}, 2'd1);
              end
              REG_NR41: nz_len_next = 7'd64 - {1'b0, b[5:0]};
              REG_NR42: if (b[7:3] == 5'd0) nz_en_next = 1'b0;
              REG_NR44: if (b[7]) begin
                nz_en_next = regs[REG_NR42][7:3] != 5'd0;
                if (nz_len == 7'd0) nz_len_next = 7'd64;
                nz_per_next = noise_period(regs[REG_NR43]);
                nz_env_next = regs[REG_NR42][2:0];
                nz_vol_next = regs[REG_NR42][7:4];
                lfsr_next = 15'h7FFF;
              end
              default: ;
            endcase
          end
        end
      end
      KIND_REG_READ: begin
        if (reg_address < 5'(RegCount)) rb = regs[reg_address];
        case (reg_address)
          REG_NR10: rd_next = rb | 8'h80;
          REG_NR11, REG_NR21: rd_next = rb | 8'h3F;
          REG_NR12, REG_NR22, REG_NR42, REG_NR43, REG_NR50, REG_NR51: rd_next = rb;
          REG_NR14, REG_NR24, REG_NR34, REG_NR44: rd_next = rb | 8'hBF;
          REG_NR30: rd_next = rb | 8'h7F;
          REG_NR32: rd_next = rb | 8'h9F;
          REG_NR52: rd_next = rb | 8'h70;
          default: rd_next = 8'hFF;
        endcase
      end
      KIND_WAVE_WRITE: wave_next[wave_address] = b;
      KIND_WAVE_READ:  rd_next = wave[wave_address];
      KIND_SAMPLE: begin
        for (int c = 0; c < 2; c++) begin
          if (!sq_en[c]) sq_lvl_next[c] = 1'b0;
          else if (sq_per[c] == 16'd0) begin
            sq_per_next[c] = reload({5'd0, regs[c*5+4][2:0], regs[c*5+3]}, 2'd2) - 16'd1;
            sq_lvl_next[c] = duty_bit(regs[c*5+1][7:6], sq_step[c]);
            sq_step_next[c] = sq_step[c] + 3'd1;
          end else sq_per_next[c] = sq_per[c] - 16'd1;
        end
        if (!wv_en) wv_lvl_next = 4'd0;
        else if (wv_per == 16'd0) begin
          wv_per_next = reload({5'd0, regs[REG_NR34][2:0], regs[REG_NR33]}, 2'd1) - 16'd1;
          wv_pos_next = wv_pos + 5'd1;
          wbyte = wave[wv_pos_next[WA:1]];
          ws = wv_pos_next[0] ? wbyte[3:0] : wbyte[7:4];
          case (regs[REG_NR32][6:5])
            2'd0: wv_lvl_next = 4'd0;
            2'd1: wv_lvl_next = ws;
            2'd2: wv_lvl_next = ws >> 1;
            default: wv_lvl_next = ws >> 2;
          endcase
        end else wv_per_next = wv_per - 16'd1;
        if (!nz_en) nz_lvl_next = 1'b0;
        else if (nz_per == 16'd0) begin
          nz_per_next = noise_period(regs[REG_NR43]) - 16'd1;
          fb = lfsr[0] ^ lfsr[1];
          sr = {fb, lfsr[14:1]};
          if (regs[REG_NR43][3]) sr[6] = fb;
          lfsr_next = sr;
          nz_lvl_next = !sr[0];
        end else nz_per_next = nz_per - 16'd1;
      end
      KIND_FRAME: begin
        if (!seq[0]) begin
          for (int c = 0; c < 2; c++)
            if (sq_en[c] && regs[c*5+4][6] && sq_len[c] != 7'd0) begin
              sq_len_next[c] = sq_len[c] - 7'd1;
              if (sq_len[c] == 7'd1) sq_en_next[c] = 1'b0;
            end
          if (wv_en && regs[REG_NR34][6] && wv_len != 9'd0) begin
            wv_len_next = wv_len - 9'd1;
            if (wv_len == 9'd1) wv_en_next = 1'b0;
          end
          if (nz_en && regs[REG_NR44][6] && nz_len != 7'd0) begin
            nz_len_next = nz_len - 7'd1;
            if (nz_len == 7'd1) nz_en_next = 1'b0;
          end
        end else if (seq == 3'd7) begin
          for (int c = 0; c < 2; c++)
            if (sq_env[c] != 3'd0) begin
              sq_env_next[c] = sq_env[c] - 3'd1;
              if (sq_env[c] == 3'd1) begin
                sq_vol_next[c] = env_vol(sq_vol[c], regs[c*5+2]);
                sq_env_next[c] = regs[c*5+2][2:0];
              end
            end
          if (nz_env != 3'd0) begin
            nz_env_next = nz_env - 3'd1;
            if (nz_env == 3'd1) begin
              nz_vol_next = env_vol(nz_vol, regs[REG_NR42]);
              nz_env_next = regs[REG_NR42][2:0];
            end
          end
        end
        seq_next = seq + 3'd1;
      end
      default: ;
    endcase
  end

  // mix uses the freshly advanced levels
  assign lv0 = sq_lvl_next[0] ? sq_vol_next[0] : 4'd0;
  assign lv1 = sq_lvl_next[1] ? sq_vol_next[1] : 4'd0;
  assign lv2 = wv_lvl_next;
  assign lv3 = nz_lvl_next ? nz_vol_next : 4'd0;

  fcsu_mix u_mix (
    .lv0(lv0), .lv1(lv1), .lv2(lv2), .lv3(lv3),
    .route(regs[REG_NR51]),
    .left_mix(mix_l), .right_mix(mix_r)
  );

  // wave table: cleared by the reset branch, written on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAVE_BYTES; i++) wave[i] <= 8'd0;
    end else if (accept) begin
      wave <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RegCount; i++) regs[i] <= 8'd0;
      for (int c = 0; c < 2; c++) begin
        sq_step[c] <= 3'd0;
        sq_vol[c] <= 4'd0;
        sq_per[c] <= 16'd0;
        sq_len[c] <= 7'd0;
        sq_env[c] <= 3'd0;
      end
      sq_en <= 2'd0;
      sq_lvl <= 2'd0;
      sweep_shadow <= 12'd0;
      sweep_active <= 1'b0;
      wv_en <= 1'b0;
      wv_pos <= 5'd0;
      wv_lvl <= 4'd0;
      wv_per <= 16'd0;
      wv_len <= 9'd0;
      nz_en <= 1'b0;
      nz_lvl <= 1'b0;
      nz_vol <= 4'd0;
      nz_per <= 16'd0;
      nz_len <= 7'd0;
      nz_env <= 3'd0;
      lfsr <= 15'h7FFF;
      seq <= 3'd0;
      out_valid <= 1'b0;
      read_data <= 8'd0;
      sample_valid <= 1'b0;
      left_sample <= 8'd0;
      right_sample <= 8'd0;
    end else begin
      if (accept) begin
        regs <= regs_next;
        sq_en <= sq_en_next;
        sq_step <= sq_step_next;
        sq_lvl <= sq_lvl_next;
        sq_vol <= sq_vol_next;
        sq_per <= sq_per_next;
        sq_len <= sq_len_next;
        sq_env <= sq_env_next;
        sweep_shadow <= sweep_shadow_next;
        sweep_active <= sweep_active_next;
        wv_en <= wv_en_next;
        wv_pos <= wv_pos_next;
        wv_lvl <= wv_lvl_next;
        wv_per <= wv_per_next;
        wv_len <= wv_len_next;
        nz_en <= nz_en_next;
        nz_lvl <= nz_lvl_next;
        nz_vol <= nz_vol_next;
        nz_per <= nz_per_next;
        nz_len <= nz_len_next;
        nz_env <= nz_env_next;
        lfsr <= lfsr_next;
        seq <= seq_next;
        // load the result register with this beat
        out_valid <= 1'b1;
        read_data <= rd_next;
        sample_valid <= kind == KIND_SAMPLE;
        left_sample <= (kind == KIND_SAMPLE) ? mix_l : 8'd0;
        right_sample <= (kind == KIND_SAMPLE) ? mix_r : 8'd0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a held result must not be overwritten by a new beat
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !accept) else $error("beat accepted over held result");
  // every accepted beat shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid) else $error("result missing after accept");
  // mix is only non-zero on a sample beat
  a_mix_only_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> left_sample == 8'd0 && right_sample == 8'd0)
    else $error("mix outside sample beat");
`endif

endmodule

// File: hw/rtl/fcsu_mix.sv
// ----------------------------------------------------------------------------
// fcsu_mix
// Routes the four channel levels and scales each side by 17/4.
// ----------------------------------------------------------------------------
module fcsu_mix (
  input  logic [3:0] lv0,
  input  logic [3:0] lv1,
  input  logic [3:0] lv2,
  input  logic [3:0] lv3,
  input  logic [7:0] route,
  output logic [7:0] left_mix,
  output logic [7:0] right_mix
);
  logic [5:0] l, r;
  logic [10:0] ls, rs;

  always_comb begin
    l = 6'd0;
    r = 6'd0;
    if (route[4]) l = l + {2'd0, lv0};
    if (route[5]) l = l + {2'd0, lv1};
    if (route[6]) l = l + {2'd0, lv2};
    if (route[7]) l = l + {2'd0, lv3};
    if (route[0]) r = r + {2'd0, lv0};
    if (route[1]) r = r + {2'd0, lv1};
    if (route[2]) r = r + {2'd0, lv2};
    if (route[3]) r = r + {2'd0, lv3};
    // sum*17 = sum*16 + sum, then drop two bits
    ls = {1'b0, l, 4'd0} + {5'd0, l};
    rs = {1'b0, r, 4'd0} + {5'd0, r};
  end

  assign left_mix  = ls[9:2];
  assign right_mix = rs[9:2];
endmodule
